>>> hw/rtl/rtp_nack_sequence_window_defines.svh
// Assertion macros for the RTP sequence window block.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef RTP_NACK_SEQUENCE_WINDOW_DEFINES_SVH
`define RTP_NACK_SEQUENCE_WINDOW_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define RNSW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define RNSW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/rnsw_pkg.sv
// Shared types and constants for the RTP sequence window block.
// No dependencies.
`default_nettype none

package rnsw_pkg;

    localparam int SEQ_W  = 16;
    localparam int VAL_W  = 16;
    localparam int SLOT_W = VAL_W + 1;   // valid flag on top of the value
    localparam int EXT_W  = 32;

    typedef logic [SEQ_W-1:0]  t_seq;
    typedef logic [VAL_W-1:0]  t_val;
    typedef logic [SLOT_W-1:0] t_slot;

    typedef enum logic [2:0] {
        K_UPDATE = 3'd0,
        K_STORE  = 3'd1,
        K_READ   = 3'd2,
        K_CLEAR  = 3'd3,
        K_RESET  = 3'd4,
        K_DROP   = 3'd5
    } t_kind;

endpackage

`default_nettype wire

>>> hw/rtl/rnsw_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module rnsw_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> hw/rtl/rtp_nack_sequence_window.sv
// RTP receive window tracker with missing-range reporting, top level.
// Uses rnsw_pkg, rnsw_ram and rtp_nack_sequence_window_defines.svh.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-----------------------------------
//  in      | input     | i_in_valid / o_in_stall   | i_kind, i_seq, i_value
//  out     | output    | o_out_valid / i_out_stall | nack, read and window status fields
//
// Update and unused kinds go from idle straight to S_FIN; store/read/drop
// pass S_QUO, S_IDX and S_MEM first. Clear-below and reset-all are the long
// ones: the slot RAM's one write port visits every entry, one per cycle.
// After reset a clearing pass writes all SLOTS entries empty,
// holding o_in_stall high the whole time.
// A result sits in the output register while the next transaction is taken;
// it only blocks once that next result is ready and the register is still full.
`default_nettype none
`include "rtp_nack_sequence_window_defines.svh"

module rtp_nack_sequence_window
    import rnsw_pkg::*;
#(
    parameter int SLOTS = 1024
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,

    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [2:0]              i_kind,
    input  wire logic [SEQ_W-1:0]        i_seq,
    input  wire logic [VAL_W-1:0]        i_value,

    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic                         o_nack_valid,
    output logic [SEQ_W-1:0]             o_nack_start,
    output logic [SEQ_W-1:0]             o_nack_end,
    output logic                         o_read_valid,
    output logic [VAL_W-1:0]             o_read_value,
    output logic [SEQ_W-1:0]             o_window_low,
    output logic [SEQ_W-1:0]             o_window_next,
    output logic signed [SEQ_W-1:0]      o_window_size,
    output logic                         o_window_empty,
    output logic [EXT_W-1:0]             o_highest_extended
);

    localparam int AW = $clog2(SLOTS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(SLOTS - 1);
    // floor(2^32 / SLOTS) + 1: exact quotient for any 16-bit numerator
    localparam logic [31:0] RECIP = 32'((64'd1 << 32) / SLOTS + 1);

    typedef enum logic [3:0] {
        S_INIT,   // clearing pass after reset
        S_IDLE,
        S_QUO,    // seq / SLOTS by reciprocal
        S_IDX,    // seq mod SLOTS
        S_MEM,    // single slot access
        S_SWEEP,  // clear-below: read every slot, write back one behind
        S_TAIL,   // last write-back of the sweep
        S_CLR,    // reset-all: write every slot empty
        S_FIN     // update window, load output register
    } t_state;

    t_state           r_state;
    t_kind            r_kind;
    t_seq             r_seq;
    t_val             r_value;
    logic [SEQ_W-1:0] r_quo;
    logic [AW-1:0]    r_idx;
    logic [AW-1:0]    r_cnt;
    logic [AW-1:0]    r_wr_addr;
    logic             r_wr_vld;

    // window state
    logic             r_started;
    t_seq             r_low;
    t_seq             r_next;
    logic [SEQ_W-1:0] r_wrap;

    // output register
    logic             r_out_valid;
    logic             r_nack_valid;
    t_seq             r_nack_start;
    t_seq             r_nack_end;
    logic             r_read_valid;
    t_val             r_read_value;
    t_seq             r_win_low;
    t_seq             r_win_next;
    logic [SEQ_W-1:0] r_win_size;
    logic             r_win_empty;
    logic [EXT_W-1:0] r_hi_ext;

    // slot RAM port
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    t_slot            ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    t_slot            ram_rdata;

    logic             in_acc;
    logic             out_free;
    logic             load;
    logic [47:0]      quo_prod;
    logic [31:0]      rem_full;
    logic             sweep_hit;

    // next window state and result fields
    logic             n_started;
    t_seq             n_low;
    t_seq             n_next;
    logic [SEQ_W-1:0] n_wrap;
    logic             n_nack_valid;
    t_seq             n_nack_start;
    t_seq             n_nack_end;
    logic             n_read_valid;
    t_val             n_read_value;
    t_seq             d_fwd;
    t_seq             d_back;

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign load       = (r_state == S_FIN) && out_free;

    // index = seq - floor(seq / SLOTS) * SLOTS, split over S_QUO and S_IDX
    assign quo_prod = 48'(r_seq) * 48'(RECIP);
    assign rem_full = 32'(r_seq) - 32'(r_quo) * 32'(SLOTS);

    // sweep: entry read last cycle is valid and its value is below seq
    assign sweep_hit = r_wr_vld && ram_rdata[SLOT_W-1] && (ram_rdata[VAL_W-1:0] < r_seq);

    rnsw_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_idx;
        case (r_state)
            S_INIT, S_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_cnt;
            end
            S_MEM: begin
                case (r_kind)
                    K_STORE: begin
                        ram_we    = 1'b1;
                        ram_wdata = {1'b1, r_value};
                    end
                    K_DROP: begin
                        ram_we = 1'b1;
                    end
                    K_READ: begin
                        ram_re = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            S_SWEEP: begin
                ram_re    = 1'b1;
                ram_raddr = r_cnt;
                ram_we    = sweep_hit;
                ram_waddr = r_wr_addr;
            end
            S_TAIL: begin
                ram_we    = sweep_hit;
                ram_waddr = r_wr_addr;
            end
            default: begin
            end
        endcase
    end

    // window update for the transaction in S_FIN
    always_comb begin
        n_started    = r_started;
        n_low        = r_low;
        n_next       = r_next;
        n_wrap       = r_wrap;
        n_nack_valid = 1'b0;
        n_nack_start = '0;
        n_nack_end   = '0;
        n_read_valid = 1'b0;
        n_read_value = '0;
        d_fwd        = r_seq - r_next;   // distance from next to seq
        d_back       = r_low - r_seq;    // distance from seq to low
        case (r_kind)
            K_UPDATE: begin
                if (!r_started) begin
                    n_started = 1'b1;
                    n_low     = r_seq;
                    n_next    = r_seq + 1'b1;
                end else if (!d_fwd[SEQ_W-1]) begin
                    // at or ahead of the end: report [next, seq]
                    n_nack_valid = 1'b1;
                    n_nack_start = r_next;
                    n_nack_end   = r_seq;
                    if (r_seq < r_next) begin
                        n_wrap = r_wrap + 1'b1;
                    end
                    n_next = r_seq + 1'b1;
                end else if (!d_back[SEQ_W-1] && (d_back != '0)) begin
                    // behind the start: report [seq, low]
                    n_nack_valid = 1'b1;
                    n_nack_start = r_seq;
                    n_nack_end   = r_low;
                    n_low        = r_seq;
                end
            end
            K_READ: begin
                n_read_valid = ram_rdata[SLOT_W-1];
                n_read_value = ram_rdata[SLOT_W-1] ? ram_rdata[VAL_W-1:0] : '0;
            end
            K_RESET: begin
                n_started = 1'b0;
                n_low     = '0;
                n_next    = '0;
            end
            K_DROP: begin
                n_low = r_seq + 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_wr_vld    <= 1'b0;
            r_started   <= 1'b0;
            r_low       <= '0;
            r_next      <= '0;
            r_wrap      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_INIT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_kind   <= t_kind'(i_kind);
                        r_seq    <= i_seq;
                        r_value  <= i_value;
                        r_cnt    <= '0;
                        r_wr_vld <= 1'b0;
                        case (t_kind'(i_kind))
                            K_STORE, K_READ, K_DROP: r_state <= S_QUO;
                            K_CLEAR:                 r_state <= S_SWEEP;
                            K_RESET:                 r_state <= S_CLR;
                            default:                 r_state <= S_FIN;
                        endcase
                    end
                end
                S_QUO: begin
                    r_quo   <= quo_prod[47:32];
                    r_state <= S_IDX;
                end
                S_IDX: begin
                    r_idx   <= rem_full[AW-1:0];
                    r_state <= S_MEM;
                end
                S_MEM: begin
                    r_state <= S_FIN;
                end
                S_SWEEP: begin
                    r_wr_vld  <= 1'b1;
                    r_wr_addr <= r_cnt;
                    r_cnt     <= r_cnt + 1'b1;
                    if (r_cnt == LAST_ADDR) begin
                        r_state <= S_TAIL;
                    end
                end
                S_TAIL: begin
                    r_wr_vld <= 1'b0;
                    r_state  <= S_FIN;
                end
                S_CLR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_ADDR) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_started    <= n_started;
                        r_low        <= n_low;
                        r_next       <= n_next;
                        r_wrap       <= n_wrap;
                        r_out_valid  <= 1'b1;
                        r_nack_valid <= n_nack_valid;
                        r_nack_start <= n_nack_start;
                        r_nack_end   <= n_nack_end;
                        r_read_valid <= n_read_valid;
                        r_read_value <= n_read_value;
                        r_win_low    <= n_low;
                        r_win_next   <= n_next;
                        r_win_size   <= n_next - n_low;
                        r_win_empty  <= (n_low == n_next);
                        // wrap * 65536 + next - 1, mod 2^32
                        r_hi_ext     <= {n_wrap, n_next} - 1'b1;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_nack_valid       = r_nack_valid;
    assign o_nack_start       = r_nack_start;
    assign o_nack_end         = r_nack_end;
    assign o_read_valid       = r_read_valid;
    assign o_read_value       = r_read_value;
    assign o_window_low       = r_win_low;
    assign o_window_next      = r_win_next;
    assign o_window_size      = $signed(r_win_size);
    assign o_window_empty     = r_win_empty;
    assign o_highest_extended = r_hi_ext;

    // no transaction is taken before the clearing pass has covered every slot
    `RNSW_ASSERT_NEXT(a_init_blocks_input, (r_state == S_INIT) && (r_cnt != LAST_ADDR), o_in_stall, "input taken during clearing pass")

    // the wrap count only moves when an update result is loaded
    `RNSW_ASSERT_NEXT(a_wrap_only_on_update, !(load && (r_kind == K_UPDATE)), $stable(r_wrap), "wrap count changed outside an update")

    // a sweep write-back only empties an entry that was valid
    `RNSW_ASSERT_NOW(a_sweep_clears_valid, ram_we && ((r_state == S_SWEEP) || (r_state == S_TAIL)), (ram_wdata == '0) && ram_rdata[SLOT_W-1], "sweep wrote a bad entry")

endmodule

`default_nettype wire

>>> tb/sv/rnsw_window_checker.sv
`timescale 1ns / 100ps
// Scoreboard for rtp_nack_sequence_window: watches both channels, predicts the window
// status of each accepted transaction and compares results in order. Uses rnsw_pkg.
module rnsw_window_checker
    import rnsw_pkg::*;
#(
    parameter int SLOTS = 1024
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic [2:0]              i_kind,
    input  logic [SEQ_W-1:0]        i_seq,
    input  logic [VAL_W-1:0]        i_value,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic                    i_nack_valid,
    input  logic [SEQ_W-1:0]        i_nack_start,
    input  logic [SEQ_W-1:0]        i_nack_end,
    input  logic                    i_read_valid,
    input  logic [VAL_W-1:0]        i_read_value,
    input  logic [SEQ_W-1:0]        i_window_low,
    input  logic [SEQ_W-1:0]        i_window_next,
    input  logic signed [SEQ_W-1:0] i_window_size,
    input  logic                    i_window_empty,
    input  logic [EXT_W-1:0]        i_highest_extended,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct packed {
        logic                    nack_valid;
        t_seq                    nack_start;
        t_seq                    nack_end;
        logic                    read_valid;
        t_val                    read_value;
        t_seq                    window_low;
        t_seq                    window_next;
        logic signed [SEQ_W-1:0] window_size;
        logic                    window_empty;
        logic [EXT_W-1:0]        highest_extended;
    } t_window_status;

    t_window_status status_q[$];
    t_window_status want_st;
    t_window_status got_st;

    // predicted block state
    logic        window_open;
    t_seq        win_low;
    t_seq        win_next;
    logic [15:0] wrap_cnt;
    t_slot       slot_mem [SLOTS];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    // signed 16-bit distance from one sequence to another
    function automatic logic signed [SEQ_W-1:0] seq_gap(input t_seq from_seq,
                                                        input t_seq to_seq);
        return to_seq - from_seq;
    endfunction

    task automatic empty_slots();
        for (int i = 0; i < SLOTS; i++)
            slot_mem[i] = '0;
    endtask

    task automatic predict_status(input logic [2:0] kind, input t_seq seq,
                                  input t_val value, output t_window_status st);
        int idx;
        idx = int'(seq) % SLOTS;
        st  = '0;
        case (kind)
            K_UPDATE: begin
                if (!window_open) begin
                    window_open = 1'b1;
                    win_low     = seq;
                    win_next    = seq + 16'd1;
                end else if (seq_gap(win_next, seq) >= 0) begin
                    st.nack_valid = 1'b1;
                    st.nack_start = win_next;
                    st.nack_end   = seq;
                    if (seq < win_next)
                        wrap_cnt = wrap_cnt + 16'd1;
                    win_next = seq + 16'd1;
                end else if (seq_gap(seq, win_low) > 0) begin
                    st.nack_valid = 1'b1;
                    st.nack_start = seq;
                    st.nack_end   = win_low;
                    win_low       = seq;
                end
            end
            K_STORE: slot_mem[idx] = {1'b1, value};
            K_READ: begin
                if (slot_mem[idx][VAL_W]) begin
                    st.read_valid = 1'b1;
                    st.read_value = slot_mem[idx][VAL_W-1:0];
                end
            end
            K_CLEAR: begin
                for (int i = 0; i < SLOTS; i++)
                    if (slot_mem[i][VAL_W] && slot_mem[i][VAL_W-1:0] < seq)
                        slot_mem[i] = '0;
            end
            K_RESET: begin
                empty_slots();
                win_low     = '0;
                win_next    = '0;
                window_open = 1'b0;
            end
            K_DROP: begin
                slot_mem[idx] = '0;
                win_low       = seq + 16'd1;
            end
            default: ;
        endcase
        st.window_low       = win_low;
        st.window_next      = win_next;
        st.window_size      = win_next - win_low;
        st.window_empty     = (win_low == win_next);
        st.highest_extended = {wrap_cnt, win_next} - 32'd1;
    endtask

    task automatic compare_field(input string fname, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, fname, exp_v, got_v);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            window_open = 1'b0;
            win_low     = '0;
            win_next    = '0;
            wrap_cnt    = '0;
            empty_slots();
            status_q.delete();
        end else begin
            // result side first, then the newly accepted transaction
            if (i_out_valid && !i_out_stall) begin
                got_st = '{i_nack_valid, i_nack_start, i_nack_end, i_read_valid,
                           i_read_value, i_window_low, i_window_next, i_window_size,
                           i_window_empty, i_highest_extended};
                if (status_q.size() == 0) begin
                    $display("%0t: result with no transaction outstanding", $time);
                    o_fail_count++;
                end else begin
                    want_st = status_q.pop_front();
                    compare_field("nack_valid", 32'(want_st.nack_valid),
                                  32'(got_st.nack_valid));
                    compare_field("nack_start", 32'(want_st.nack_start),
                                  32'(got_st.nack_start));
                    compare_field("nack_end", 32'(want_st.nack_end),
                                  32'(got_st.nack_end));
                    compare_field("read_valid", 32'(want_st.read_valid),
                                  32'(got_st.read_valid));
                    compare_field("read_value", 32'(want_st.read_value),
                                  32'(got_st.read_value));
                    compare_field("window_low", 32'(want_st.window_low),
                                  32'(got_st.window_low));
                    compare_field("window_next", 32'(want_st.window_next),
                                  32'(got_st.window_next));
                    compare_field("window_size", 32'(want_st.window_size),
                                  32'(got_st.window_size));
                    compare_field("window_empty", 32'(want_st.window_empty),
                                  32'(got_st.window_empty));
                    compare_field("highest_extended", want_st.highest_extended,
                                  got_st.highest_extended);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                predict_status(i_kind, i_seq, i_value, want_st);
                status_q.push_back(want_st);
            end
        end
        o_pending = status_q.size();
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps
// Top of the rtp_nack_sequence_window testbench: clock, reset, stimulus and verdict.
// Depends on rnsw_pkg, the block itself and rnsw_window_checker.
module tb
    import rnsw_pkg::*;
();

    localparam int SLOTS        = 1024;
    localparam int RANDOM_ITEMS = 1300;   // non-ignored random transactions
    localparam int QUIET_FROM   = 1100;   // no idling on either side after this
    localparam int HOLD_CYCLES  = 300;    // long receiver hold-off
    localparam int DRAIN_CYCLES = 40;     // settle time after the last result

    // kind codes the block ignores
    localparam logic [2:0] K_SPARE_LO = 3'd6;
    localparam logic [2:0] K_SPARE_HI = 3'd7;

    logic                    i_clk        = 1'b0;
    logic                    i_rst_n      = 1'b0;
    logic                    i_in_valid   = 1'b0;
    logic [2:0]              i_kind       = '0;
    logic [SEQ_W-1:0]        i_seq        = '0;
    logic [VAL_W-1:0]        i_value      = '0;
    logic                    i_out_stall  = 1'b0;
    logic                    o_in_stall;
    logic                    o_out_valid;
    logic                    o_nack_valid;
    logic [SEQ_W-1:0]        o_nack_start;
    logic [SEQ_W-1:0]        o_nack_end;
    logic                    o_read_valid;
    logic [VAL_W-1:0]        o_read_value;
    logic [SEQ_W-1:0]        o_window_low;
    logic [SEQ_W-1:0]        o_window_next;
    logic signed [SEQ_W-1:0] o_window_size;
    logic                    o_window_empty;
    logic [EXT_W-1:0]        o_highest_extended;

    int fail_count;
    int pending;

    // pacing controls shared between the sender and the receiver process
    logic long_hold = 1'b0;   // receiver holds off for HOLD_CYCLES
    logic rx_quiet  = 1'b0;   // receiver never stalls
    logic tx_quiet  = 1'b0;   // sender never idles
    logic tx_calm   = 1'b0;   // temporary stretch without sender gaps

    rtp_nack_sequence_window #(
        .SLOTS(SLOTS)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_kind             (i_kind),
        .i_seq              (i_seq),
        .i_value            (i_value),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_nack_valid       (o_nack_valid),
        .o_nack_start       (o_nack_start),
        .o_nack_end         (o_nack_end),
        .o_read_valid       (o_read_valid),
        .o_read_value       (o_read_value),
        .o_window_low       (o_window_low),
        .o_window_next      (o_window_next),
        .o_window_size      (o_window_size),
        .o_window_empty     (o_window_empty),
        .o_highest_extended (o_highest_extended)
    );

    rnsw_window_checker #(
        .SLOTS(SLOTS)
    ) u_checker (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_in_stall         (o_in_stall),
        .i_kind             (i_kind),
        .i_seq              (i_seq),
        .i_value            (i_value),
        .i_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .i_nack_valid       (o_nack_valid),
        .i_nack_start       (o_nack_start),
        .i_nack_end         (o_nack_end),
        .i_read_valid       (o_read_valid),
        .i_read_value       (o_read_value),
        .i_window_low       (o_window_low),
        .i_window_next      (o_window_next),
        .i_window_size      (o_window_size),
        .i_window_empty     (o_window_empty),
        .i_highest_extended (o_highest_extended),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop. The slowest legal run is dominated by clear and reset-all
    // transactions (each visits every slot, a few percent of the mix) plus the
    // post-reset clearing pass; 8 ms is roughly ten times that.
    initial begin
        #(8_000_000);
        $display("end of test: mismatches");
        $finish;
    end

    // ---------------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------------

    // Present one transaction and hold it until the block takes it. Valid is
    // only raised here; lowering it is left to idle_sender / wait_drain so a
    // back-to-back transaction never sees valid dropped and raised in one step.
    task automatic send_txn(input logic [2:0] kind, input logic [15:0] seq,
                            input logic [15:0] value);
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_seq      <= seq;
        i_value    <= value;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic idle_sender(input int cycles);
        i_in_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Random gap bursts between transactions, except during calm stretches,
    // the long receiver hold (sender must keep pushing) and the final part.
    task automatic pace_sender();
        if (!tx_quiet && !tx_calm && !long_hold && $urandom_range(0, 4) == 0)
            idle_sender($urandom_range(1, 12));
    endtask

    // Stop offering and wait until every predicted result has come back.
    // The loop waits on the clock before testing pending, so the checker has seen the last handshake.
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // ---------------------------------------------------------------------
    // Receiver side: stall bursts, calm stretches, one long hold-off
    // ---------------------------------------------------------------------
    initial begin
        forever begin
            if (long_hold) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (!rx_quiet && $urandom_range(0, 5) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else if (!rx_quiet && $urandom_range(0, 40) == 0) begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(20, 80)) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------------
    initial begin
        int                 work_items;
        int                 sent;
        int                 r;
        logic               hold_fired;
        logic               pause_fired;
        logic [2:0]         kind;
        logic [15:0]        seq;
        logic [15:0]        value;
        logic [15:0]        cursor;      // highest sequence pushed so far
        logic signed [15:0] step;
        logic [15:0]        pos_pool [8]; // recently stored slot positions

        work_items  = 0;
        sent        = 0;
        hold_fired  = 1'b0;
        pause_fired = 1'b0;
        cursor      = '0;
        for (int i = 0; i < 8; i++)
            pos_pool[i] = 16'($urandom_range(0, 16'hFFFF));

        // synchronous reset; the block then runs its slot clearing pass with
        // o_in_stall high, which send_txn simply waits out
        i_rst_n <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed part ----
        // window start near the top of the space, update equal to next,
        // wrap of the high end, update inside the window (no range)
        send_txn(K_UPDATE, 16'hFFFD, 16'h0000);   pace_sender();
        send_txn(K_UPDATE, 16'hFFFE, 16'hFFFF);   pace_sender();
        send_txn(K_UPDATE, 16'h0002, 16'h0000);   pace_sender();
        send_txn(K_UPDATE, 16'h0001, 16'h0000);   pace_sender();
        // late packet behind the window start, then the largest distances:
        // exactly half the space behind, and just under half ahead
        send_txn(K_UPDATE, 16'hFFF0, 16'h0000);   pace_sender();
        send_txn(K_UPDATE, 16'h8003, 16'h0000);   pace_sender();
        send_txn(K_UPDATE, 16'h8002, 16'h0000);   pace_sender();
        // slot extremes; a stored zero must read back as a valid zero
        send_txn(K_STORE, 16'hFFFF, 16'hFFFF);    pace_sender();
        send_txn(K_STORE, 16'h0000, 16'h0000);    pace_sender();
        send_txn(K_READ, 16'h0400, 16'h0000);     pace_sender();
        send_txn(K_READ, 16'h03FF, 16'hFFFF);     pace_sender();
        send_txn(K_READ, 16'h0005, 16'h0000);     pace_sender();
        // clear below the top value keeps only the all-ones slot
        send_txn(K_CLEAR, 16'hFFFF, 16'h0000);    pace_sender();
        send_txn(K_READ, 16'h0000, 16'h0000);     pace_sender();
        send_txn(K_READ, 16'hFFFF, 16'h0000);     pace_sender();
        send_txn(K_CLEAR, 16'h0000, 16'hFFFF);    pace_sender();
        // drop at the top sequence moves the window start across the wrap
        send_txn(K_DROP, 16'hFFFF, 16'h0000);     pace_sender();
        send_txn(K_READ, 16'hFFFF, 16'h0000);     pace_sender();
        // ignored kind codes
        send_txn(K_SPARE_LO, 16'hFFFF, 16'hFFFF); pace_sender();
        send_txn(K_SPARE_HI, 16'h0000, 16'h0000); pace_sender();
        // reset-all empties slots and restarts the window, wrap count kept
        send_txn(K_STORE, 16'h1234, 16'h00AA);    pace_sender();
        send_txn(K_RESET, 16'h0000, 16'h0000);    pace_sender();
        send_txn(K_READ, 16'h1234, 16'h0000);     pace_sender();
        send_txn(K_UPDATE, 16'h0000, 16'h0000);   pace_sender();
        send_txn(K_UPDATE, 16'h0000, 16'h0000);
        cursor = 16'h0000;

        // sender pause with everything returned
        wait_drain();

        // ---- random part ----
        // Mostly an in-order packet stream with gaps and reordering around the
        // cursor, so nack ranges and wraps keep happening; slot traffic reuses
        // recent positions so reads often hit stored entries.
        while (work_items < RANDOM_ITEMS) begin
            if (sent % 50 == 0)
                tx_calm = ($urandom_range(0, 3) == 0);
            r     = $urandom_range(0, 199);
            value = 16'($urandom_range(0, 16'hFFFF));
            seq   = 16'($urandom_range(0, 16'hFFFF));
            if (r < 110) begin
                kind = K_UPDATE;
                r    = $urandom_range(0, 19);
                if (r < 12)
                    seq = cursor + 16'($urandom_range(0, 4));
                else if (r < 16)
                    seq = cursor + 16'($urandom_range(5, 60));
                else if (r < 18)
                    seq = cursor - 16'($urandom_range(1, 40));
                else if (r == 18)
                    seq = cursor + 16'($urandom_range(16'h7F00, 16'h8100));
                step = seq - cursor;
                if (step > 0)
                    cursor = seq;
            end else if (r < 135) begin
                kind = K_STORE;
                if ($urandom_range(0, 1) == 0)
                    seq = pos_pool[$urandom_range(0, 7)];
                pos_pool[$urandom_range(0, 7)] = seq;
                if ($urandom_range(0, 3) == 0)
                    value = 16'($urandom_range(0, 255));
            end else if (r < 165) begin
                kind = K_READ;
                if ($urandom_range(0, 3) != 0)
                    seq = pos_pool[$urandom_range(0, 7)];
            end else if (r < 170) begin
                kind = K_CLEAR;
            end else if (r < 173) begin
                kind = K_RESET;
            end else if (r < 190) begin
                kind = K_DROP;
                if ($urandom_range(0, 3) != 0)
                    seq = cursor - 16'($urandom_range(0, 30));
            end else begin
                kind = ($urandom_range(0, 1) == 0) ? K_SPARE_LO : K_SPARE_HI;
            end

            send_txn(kind, seq, value);
            sent++;
            if (kind != K_SPARE_LO && kind != K_SPARE_HI)
                work_items++;

            // long receiver hold while the sender keeps offering: the output
            // register fills and the block must push back on its input
            if (work_items == 300 && !hold_fired) begin
                hold_fired = 1'b1;
                long_hold  = 1'b1;
            end
            // second full drain in the middle of the run
            if (work_items == 700 && !pause_fired) begin
                pause_fired = 1'b1;
                wait_drain();
            end
            // final stretch runs with both sides at full rate
            if (work_items >= QUIET_FROM) begin
                tx_quiet = 1'b1;
                rx_quiet = 1'b1;
            end
            pace_sender();
        end

        // ---- wrap-up ----
        wait_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending != 0)
            $display("%0t: %0d results never arrived", $time, pending);
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> rtp_nack_sequence_window.f
+incdir+hw/rtl
hw/rtl/rnsw_pkg.sv
hw/rtl/rnsw_ram.sv
hw/rtl/rtp_nack_sequence_window.sv
tb/sv/rnsw_window_checker.sv
tb/sv/tb.sv
